// ===== hdl/lfu_pkg.sv =====
// Shared types and constants for the LFU cache table.
// Used by the request queue, the table engine, the top level and the testbench.
`default_nettype none
package lfu_pkg;

	localparam int ENTRIES = 16;
	localparam int COUNT_W = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int HELD_W = $clog2(ENTRIES + 1);
	localparam int CAP_W = 5;
	localparam int LIM_W = (HELD_W > CAP_W) ? HELD_W : CAP_W;
	localparam int LEAVES = 1 << IDX_W;
	localparam int SCORE_W = 1 + COUNT_W + IDX_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);
	localparam logic signed [31:0] MISS_VALUE = -32'sd1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD
	} eng_state_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] key;
		logic signed [31:0] wval;
	} item_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/lfu_if.sv =====
// Request and response channel interfaces (valid/ready) for the LFU cache table.
// Depends on nothing; payload widths follow the request and response words.
`default_nettype none
interface lfu_req_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] key;
	logic signed [31:0] write_value;

	modport source(output valid, output opcode, output key, output write_value, input ready);
	modport sink(input valid, input opcode, input key, input write_value, output ready);
endinterface

interface lfu_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] read_value;
	logic               evicted;
	logic signed [31:0] evicted_key;

	modport source(output valid, output hit, output read_value, output evicted,
		output evicted_key, input ready);
	modport sink(input valid, input hit, input read_value, input evicted,
		input evicted_key, output ready);
endinterface
`default_nettype wire

// ===== hdl/lfu_front.sv =====
// Front end: accepts request words, decodes the opcode, and queues them (two deep).
// Depends on lfu_pkg and lfu_req_if.
`default_nettype none
module lfu_front (
	input  wire                 clk,
	input  wire                 arst_n,
	lfu_req_if.sink             req,
	output logic                pop_valid,
	input  wire                 pop_ready,
	output lfu_pkg::item_t      pop_item
);

	lfu_pkg::item_t buf_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;

	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign pop_valid = (cnt_q != 2'd0);
	assign pop       = pop_valid && pop_ready;
	assign pop_item  = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q].op   <= req.opcode ? lfu_pkg::OP_PUT : lfu_pkg::OP_GET;
			buf_q[wr_ptr_q].key  <= req.key;
			buf_q[wr_ptr_q].wval <= req.write_value;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lfu_engine.sv =====
// Back end: slot table with key match, LFU/LRU victim tree, update and result register.
// Depends on lfu_pkg and lfu_rsp_if.
`default_nettype none
module lfu_engine (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire [lfu_pkg::CAP_W-1:0]    cap,
	input  wire                         pop_valid,
	output logic                        pop_ready,
	input  lfu_pkg::item_t              pop_item,
	lfu_rsp_if.source                   rsp
);

	localparam int IW = lfu_pkg::IDX_W;
	localparam int CW = lfu_pkg::COUNT_W;

	lfu_pkg::eng_state_t state_q, state_d;
	lfu_pkg::item_t      item_q;
	logic                load;
	logic                upd_fire;
	logic                out_free;

	logic                  valid_q [lfu_pkg::ENTRIES];
	logic signed [31:0]    key_q   [lfu_pkg::ENTRIES];
	logic signed [31:0]    val_q   [lfu_pkg::ENTRIES];
	logic [CW-1:0]         cnt_q   [lfu_pkg::ENTRIES];
	logic [IW-1:0]         rank_q  [lfu_pkg::ENTRIES];

	lfu_pkg::result_t rsp_q;
	logic             rsp_vld_q;

	// lookup
	logic                       found;
	logic [IW-1:0]              found_idx;
	logic                       free_any;
	logic [IW-1:0]              free_idx;
	logic [lfu_pkg::HELD_W-1:0] held;
	logic [lfu_pkg::SCORE_W-1:0] node_score [2*lfu_pkg::LEAVES];
	logic [IW-1:0]               node_idx   [2*lfu_pkg::LEAVES];

	logic                       found_s1;
	logic [IW-1:0]              found_idx_s1;
	logic                       free_any_s1;
	logic [IW-1:0]              free_idx_s1;
	logic [IW-1:0]              victim_s1;
	logic [lfu_pkg::HELD_W-1:0] held_s1;

	// update decode
	logic [lfu_pkg::LIM_W-1:0] limit;
	logic                      is_put;
	logic                      do_touch;
	logic                      do_evict;
	logic                      do_fill;
	logic [IW-1:0]             old_rank;
	lfu_pkg::result_t          res;

	assign out_free  = !rsp_vld_q || rsp.ready;
	assign upd_fire  = (state_q == lfu_pkg::ST_UPD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lfu_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		unique case (state_q)
			lfu_pkg::ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) state_d = lfu_pkg::ST_LOOK;
			end
			lfu_pkg::ST_LOOK: begin
				state_d = lfu_pkg::ST_UPD;
			end
			lfu_pkg::ST_UPD: begin
				if (out_free) begin
					pop_ready = 1'b1;
					state_d   = pop_valid ? lfu_pkg::ST_LOOK : lfu_pkg::ST_IDLE;
				end
			end
			default: state_d = lfu_pkg::ST_IDLE;
		endcase
	end

	assign load = pop_ready && pop_valid;

	always_ff @(posedge clk) begin
		if (load) item_q <= pop_item;
	end

	// key match, first free slot, occupancy
	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		free_any  = 1'b0;
		free_idx  = '0;
		held      = '0;
		for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == item_q.key) begin
				found     = 1'b1;
				found_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
			held = held + lfu_pkg::HELD_W'(valid_q[i]);
		end
	end

	// victim tree: lowest {count, ~rank} among valid slots; valid ranks are unique.
	// Empty slots score all ones so their unwritten count and rank never matter.
	always_comb begin
		node_score[0] = '1;
		node_idx[0]   = '0;
		for (int i = 0; i < lfu_pkg::LEAVES; i++) begin
			if (i < lfu_pkg::ENTRIES && valid_q[i]) begin
				node_score[lfu_pkg::LEAVES + i] = {1'b0, cnt_q[i], ~rank_q[i]};
			end else begin
				node_score[lfu_pkg::LEAVES + i] = '1;
			end
			node_idx[lfu_pkg::LEAVES + i] = IW'(i);
		end
		for (int n = lfu_pkg::LEAVES - 1; n >= 1; n--) begin
			if (node_score[2*n+1] < node_score[2*n]) begin
				node_score[n] = node_score[2*n+1];
				node_idx[n]   = node_idx[2*n+1];
			end else begin
				node_score[n] = node_score[2*n];
				node_idx[n]   = node_idx[2*n];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lfu_pkg::ST_LOOK) begin
			found_s1     <= found;
			found_idx_s1 <= found_idx;
			free_any_s1  <= free_any;
			free_idx_s1  <= free_idx;
			victim_s1    <= node_idx[1];
			held_s1      <= held;
		end
	end

	always_comb begin
		if (lfu_pkg::LIM_W'(cap) > lfu_pkg::LIM_W'(lfu_pkg::ENTRIES))
			limit = lfu_pkg::LIM_W'(lfu_pkg::ENTRIES);
		else
			limit = lfu_pkg::LIM_W'(cap);
		is_put   = (item_q.op == lfu_pkg::OP_PUT);
		do_touch = found_s1 && (!is_put || limit != '0);
		do_evict = is_put && !found_s1 && limit != '0 && held_s1 != '0
			&& lfu_pkg::LIM_W'(held_s1) >= limit;
		do_fill  = is_put && !found_s1 && limit != '0 && !do_evict && free_any_s1;
		old_rank = found_s1 ? rank_q[found_idx_s1] : rank_q[victim_s1];

		res.hit         = found_s1;
		res.read_value  = '0;
		res.evicted     = do_evict;
		res.evicted_key = do_evict ? key_q[victim_s1] : '0;
		if (!is_put) res.read_value = found_s1 ? val_q[found_idx_s1] : lfu_pkg::MISS_VALUE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lfu_pkg::ENTRIES; i++) valid_q[i] <= 1'b0;
		end else if (upd_fire && do_fill) begin
			valid_q[free_idx_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
				if (valid_q[i]) begin
					if (do_touch) begin
						if (IW'(i) == found_idx_s1) begin
							rank_q[i] <= '0;
							if (cnt_q[i] != lfu_pkg::COUNT_MAX)
								cnt_q[i] <= cnt_q[i] + lfu_pkg::COUNT_ONE;
						end else if (rank_q[i] < old_rank) begin
							rank_q[i] <= rank_q[i] + IW'(1);
						end
					end
					// evict: drop victim then age all; older than victim nets zero
					if (do_evict && IW'(i) != victim_s1 && rank_q[i] < old_rank)
						rank_q[i] <= rank_q[i] + IW'(1);
					if (do_fill) rank_q[i] <= rank_q[i] + IW'(1);
				end
			end
			if (do_touch && is_put) val_q[found_idx_s1] <= item_q.wval;
			if (do_evict || do_fill) begin
				key_q[do_evict ? victim_s1 : free_idx_s1]  <= item_q.key;
				val_q[do_evict ? victim_s1 : free_idx_s1]  <= item_q.wval;
				cnt_q[do_evict ? victim_s1 : free_idx_s1]  <= lfu_pkg::COUNT_ONE;
				rank_q[do_evict ? victim_s1 : free_idx_s1] <= '0;
			end
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       rsp_vld_q <= 1'b0;
		else if (upd_fire) rsp_vld_q <= 1'b1;
		else if (rsp.ready) rsp_vld_q <= 1'b0;
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.hit         = rsp_q.hit;
	assign rsp.read_value  = rsp_q.read_value;
	assign rsp.evicted     = rsp_q.evicted;
	assign rsp.evicted_key = rsp_q.evicted_key;

endmodule
`default_nettype wire

// ===== hdl/lfu_cache_table_core.sv =====
// Top level of the LFU cache table: capacity register, request queue and table engine.
// Depends on lfu_pkg, lfu_if, lfu_front and lfu_engine.
`default_nettype none
// Sixteen-slot key/value store with least-frequently-used replacement, oldest
// first among equal use counts. Each request word gives one response word. A
// request goes through a lookup state (parallel key match, victim tree over
// all slots, results registered) and an update state (count/rank write-back,
// response register); the next request enters as the update state ends. A
// two-deep queue in front takes requests while the engine works or a response
// waits. Capacity is to be written only while idle; no logic enforces it.
module lfu_cache_table_core (
	input  wire                      clk,
	input  wire                      arst_n,
	lfu_req_if.sink                  req,
	lfu_rsp_if.source                rsp,
	input  wire                      cfg_we,
	input  wire [lfu_pkg::CAP_W-1:0] cfg_wdata
);

	logic [lfu_pkg::CAP_W-1:0] cap_q;
	logic                      pop_valid;
	logic                      pop_ready;
	lfu_pkg::item_t            pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     cap_q <= lfu_pkg::CAP_RESET;
		else if (cfg_we) cap_q <= cfg_wdata;
	end

	lfu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	lfu_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.rsp       (rsp)
	);

	// an eviction only happens on a put miss
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.evicted |-> !rsp.hit && rsp.read_value == 32'sd0)
		else $error("eviction reported on a hit or with nonzero read word");

	a_evkey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.evicted |-> rsp.evicted_key == 32'sd0)
		else $error("evicted key nonzero without eviction");

	// a stalled response word holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.hit)
			&& $stable(rsp.read_value) && $stable(rsp.evicted)
			&& $stable(rsp.evicted_key))
		else $error("response word changed while stalled");

endmodule
`default_nettype wire

// ===== sim/lfu_tb_if.sv =====
// Testbench-side copy of nothing: the channel interfaces come from hdl/lfu_if.sv.
// This file holds shared testbench types; depends on lfu_pkg.
`timescale 1ns / 1ps
package lfu_tb_pkg;
	import lfu_pkg::*;

	// expected response word
	typedef struct {
		logic               hit;
		logic signed [31:0] read_value;
		logic               evicted;
		logic signed [31:0] evicted_key;
	} lfu_resp_t;
endpackage

// ===== sim/testbench.sv =====
// Self-checking testbench for lfu_cache_table_core: random and directed get/put
// traffic, a behavioral LFU table with age ranks predicts every response word.
// Depends on lfu_pkg, lfu_if (hdl) and lfu_tb_pkg.
`timescale 1ns / 1ps
module testbench;
	import lfu_pkg::*;
	import lfu_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	lfu_req_if req();
	lfu_rsp_if rsp();

	lfu_cache_table_core u_dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow table
	logic [CAP_W-1:0]   cap_shadow;
	logic               tv [ENTRIES];
	logic [31:0]        tkey [ENTRIES];
	logic [31:0]        tval [ENTRIES];
	logic [COUNT_W-1:0] tcnt [ENTRIES];
	int unsigned        tage [ENTRIES];

	lfu_resp_t pending_resp[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_rsp = 1'b0;
	int idle_cycles = 0;
	logic [31:0] used_keys[$];

	initial begin
		req.valid = 1'b0;
		req.opcode = 1'b0;
		req.key = '0;
		req.write_value = '0;
		rsp.ready = 1'b0;
	end

	task automatic table_clear();
		cap_shadow = CAP_RESET;
		for (int i = 0; i < ENTRIES; i++) begin
			tv[i] = 1'b0;
			tkey[i] = '0;
			tval[i] = '0;
			tcnt[i] = '0;
			tage[i] = 0;
		end
	endtask

	function automatic void promote(int s);
		int unsigned old;
		old = tage[s];
		for (int i = 0; i < ENTRIES; i++)
			if (tv[i] && i != s && tage[i] < old)
				tage[i]++;
		tage[s] = 0;
		if (tcnt[s] != COUNT_MAX)
			tcnt[s]++;
	endfunction

	function automatic lfu_resp_t lfu_lookup(logic is_put, logic [31:0] k, logic [31:0] v);
		lfu_resp_t r;
		int found, freeslot, victim, lim, held;
		int unsigned old;
		found = -1;
		freeslot = -1;
		victim = -1;
		held = 0;
		lim = (cap_shadow < ENTRIES) ? cap_shadow : ENTRIES;
		for (int i = 0; i < ENTRIES; i++) begin
			if (tv[i]) begin
				held++;
				if (found < 0 && tkey[i] == k)
					found = i;
				if (victim < 0 || tcnt[i] < tcnt[victim] ||
						(tcnt[i] == tcnt[victim] && tage[i] > tage[victim]))
					victim = i;
			end else if (freeslot < 0) begin
				freeslot = i;
			end
		end
		r.hit = (found >= 0);
		r.read_value = '0;
		r.evicted = 1'b0;
		r.evicted_key = '0;
		if (is_put == OP_GET) begin
			if (found >= 0) begin
				r.read_value = tval[found];
				promote(found);
			end else begin
				r.read_value = MISS_VALUE;
			end
			return r;
		end
		if (lim == 0)
			return r;
		if (found >= 0) begin
			tval[found] = v;
			promote(found);
			return r;
		end
		if (held >= lim && victim >= 0) begin
			r.evicted = 1'b1;
			r.evicted_key = tkey[victim];
			old = tage[victim];
			tv[victim] = 1'b0;
			for (int i = 0; i < ENTRIES; i++)
				if (tv[i] && tage[i] > old)
					tage[i]--;
			freeslot = victim;
		end
		if (freeslot < 0)
			return r;
		for (int i = 0; i < ENTRIES; i++)
			if (tv[i])
				tage[i]++;
		tv[freeslot] = 1'b1;
		tkey[freeslot] = k;
		tval[freeslot] = v;
		tcnt[freeslot] = COUNT_ONE;
		tage[freeslot] = 0;
		return r;
	endfunction

	// send one request word; prediction made at acceptance.
	// valid stays up on return; the next word reuses it or drain() takes it down.
	task automatic send_word(op_t op, logic [31:0] k, logic [31:0] v);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.opcode <= op;
		req.key <= k;
		req.write_value <= v;
		do @(posedge clk); while (!req.ready);
		pending_resp.insert(pending_resp.size(), lfu_lookup(op, k, v));
		if (op == OP_PUT)
			used_keys.insert(used_keys.size(), k);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_resp.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] c);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_shadow = c;
	endtask

	function automatic logic [31:0] pick_key();
		if (used_keys.size() != 0 && $urandom_range(3, 0) != 0)
			return used_keys[$urandom_range(used_keys.size() - 1, 0)];
		return $urandom_range(23, 0) == 0 ? $urandom() : $urandom_range(40, 0) - 8;
	endfunction

	task automatic random_words(int n, int hot_pct);
		op_t op;
		for (int i = 0; i < n; i++) begin
			op = ($urandom_range(99, 0) < hot_pct) ? OP_PUT : OP_GET;
			send_word(op, pick_key(), $urandom());
		end
	endtask

	// directed: extremes, both ops, misses, hits, eviction and tie-break
	task automatic test_directed();
		send_word(OP_GET, 32'h8000_0000, '0);
		send_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(OP_PUT, 32'h0, 32'h0);
		send_word(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(OP_GET, 32'h7FFF_FFFF, '0);
		send_word(OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
		send_word(OP_GET, 32'hFFFF_FFFF, '0);
		for (int k = 1; k <= 14; k++)
			send_word(OP_PUT, k, ~k);
		send_word(OP_PUT, 32'd100, 32'd5);
	endtask

	// capacity zero and over-range; lowered capacity with held entries
	task automatic test_capacity();
		set_capacity('0);
		send_word(OP_PUT, 32'd3, 32'd9);
		send_word(OP_PUT, 32'd555, 32'd9);
		send_word(OP_GET, 32'd3, '0);
		set_capacity(5'd31);
		random_words(60, 60);
		set_capacity(5'd3);
		random_words(60, 60);
		set_capacity(5'd1);
		random_words(40, 60);
	endtask

	// one heavily used entry survives a burst of new puts
	task automatic test_hot_entry();
		set_capacity(5'd16);
		send_word(OP_PUT, 32'hCAFE, 32'd1);
		for (int i = 0; i < 60; i++)
			send_word(OP_GET, 32'hCAFE, '0);
		for (int k = 0; k < 20; k++)
			send_word(OP_PUT, 32'h5000 + k, k);
		send_word(OP_GET, 32'hCAFE, '0);
	endtask

	task automatic test_idling();
		int cps [4] = '{0, 66, 0, 20};
		int crs [4] = '{0, 0, 66, 20};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = cps[p];
			recv_stall_pct = crs[p];
			set_capacity(CAP_W'($urandom_range(16, 2)));
			random_words(200, 55);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_rsp = 1'b1;
		random_words(60, 50);
	endtask

	initial begin
		table_clear();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_capacity();
		test_idling();
		test_backpressure();
		test_hot_entry();
		drain();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// long receiver hold-off, counted here
	initial begin
		wait (hold_rsp);
		repeat (300) @(negedge clk);
		hold_rsp = 1'b0;
	end

	always @(negedge clk)
		rsp.ready <= !hold_rsp && !(recv_stall_pct > 0 &&
			$urandom_range(99, 0) < recv_stall_pct);

	always @(posedge clk) begin
		lfu_resp_t e;
		if (rsp.valid && rsp.ready) begin
			if (pending_resp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response word: hit=%0b rd=%h", rsp.hit,
						rsp.read_value);
			end else begin
				e = pending_resp[0];
				pending_resp.delete(0);
				if (rsp.hit !== e.hit || rsp.read_value !== e.read_value ||
						rsp.evicted !== e.evicted || rsp.evicted_key !== e.evicted_key) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp hit=%0b rd=%h ev=%0b ek=%h, got hit=%0b rd=%h ev=%0b ek=%h",
							e.hit, e.read_value, e.evicted, e.evicted_key,
							rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key);
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || hold_rsp)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
